>>> rtl/etccr_pkg.sv
// Package for the edge-timestamp clock recovery PLL.
// Holds widths, reset values, loop gains, payload types and the control/status structs.
// No dependencies.
package etccr_pkg;

    localparam int TIME_W = 48;   // timestamp width
    localparam int NOM_W  = 40;   // integer period width
    localparam int FRAC_W = 16;   // period fraction bits
    localparam int PER_W  = 56;   // fixed-point period width
    localparam int POS_W  = 64;   // NCO position width
    localparam int DPH_W  = 66;   // raw phase error width
    localparam int DIV_W  = 64;   // divider dividend / quotient width
    localparam int DVS_W  = 48;   // divider divisor width
    localparam int MAG_W  = 62;   // saturated error magnitude width
    localparam int GAIN_W = 25;   // Q32 gain width
    localparam int PROD_W = 57;   // 32 x 25 product
    localparam int ACC_W  = 58;
    localparam int TERM_W = 60;
    localparam int UIC_W  = 46;   // saturated integer error width

    localparam logic [NOM_W-1:0]  NOM_RST  = 40'd800000;
    localparam logic [NOM_W-1:0]  MINP_RST = 40'd2;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [UIC_W-1:0]  UI_LIM   = {UIC_W{1'b1}};
    localparam logic [MAG_W-1:0]  Q_LIM    = {MAG_W{1'b1}};
    localparam logic [PER_W-1:0]  PER_MAX  = {PER_W{1'b1}};

    localparam logic [GAIN_W-1:0] G_FREQ  = 25'd25769804;  // 0.006
    localparam logic [GAIN_W-1:0] G_PHASE = 25'd8589935;   // 0.002
    localparam logic [GAIN_W-1:0] G_BANG  = 25'd10737418;  // 0.0025

    typedef struct packed {
        logic [TIME_W-1:0] edge_time;
        logic              final_edge;
    } t_in;

    typedef struct packed {
        logic [TIME_W-1:0] tick_time;
        logic [1:0]        tick_status;
        logic              run_last;
    } t_out;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_NYQUIST  = 2'd1,
        ST_OVERRUN  = 2'd2,
        ST_END      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_NOMINAL     = 2'd0,
        CFG_MIN_PERIOD  = 2'd1,
        CFG_CAPTURE_END = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MOP_NONE = 3'd0,
        MOP_FHI  = 3'd1,
        MOP_FLO  = 3'd2,
        MOP_PHI  = 3'd3,
        MOP_PLO  = 3'd4,
        MOP_BHI  = 3'd5,
        MOP_BLO  = 3'd6
    } t_mop;

    typedef struct packed {
        logic    take;
        logic    seed;
        logic    set_half;
        logic    set_prev;
        logic    f1;
        logic    f2;
        logic    f3;
        logic    div_start;
        logic    div_sel;     // 0: UI count, 1: per-UI length
        logic    take_n;
        logic    freq_off;
        logic    fdp;
        logic    mag;
        t_mop    mop;
        logic    term_freq;
        logic    term_phase;
        logic    pupd;
        logic    tp_upd;
        logic    nudge;
        logic    adv;
        logic    emit;
        t_status emit_status;
        logic    pend_wr;
        t_status pend_status;
        logic    finalize;
    } t_cmd;

    typedef struct packed {
        logic fin;
        logic have_prev;
        logic fold;
        logic cap_hit;
        logic freq_en;
        logic n_zero;
        logic div_busy;
        logic nyq;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/etccr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on etccr_pkg (widths).
module etccr_div import etccr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic [DIV_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_d;

    logic [DVS_W:0]   w_sh;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_sh   = {r_rem, r_q[DIV_W-1]};
    assign w_diff = w_sh - {1'b0, r_d};
    assign w_ge   = (w_sh >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_sh[DVS_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

>>> rtl/etccr_dp.sv
// Datapath: config registers, NCO state, loop-filter arithmetic, pending tick and output beat.
// Depends on etccr_pkg and etccr_div.
module etccr_dp import etccr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in               i_in,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [TIME_W-1:0] i_cfg_data,
    output t_out              o_out,
    output logic              o_out_valid,
    input  logic              i_out_ready
);

    function automatic logic [MAG_W:0] f_mag(input logic signed [DPH_W-1:0] x);
        logic [DPH_W-1:0] a;
        begin
            a = x[DPH_W-1] ? DPH_W'(-x) : DPH_W'(x);
            if (a > DPH_W'(Q_LIM)) begin
                f_mag = {x[DPH_W-1], Q_LIM};
            end else begin
                f_mag = {x[DPH_W-1], a[MAG_W-1:0]};
            end
        end
    endfunction

    // config
    logic [NOM_W-1:0]  r_nom, r_minp;
    logic [TIME_W-1:0] r_cap;

    // item and loop state
    logic [TIME_W-1:0] r_edge;
    logic              r_fin;
    logic [POS_W-1:0]  r_pos;
    logic [PER_W-1:0]  r_pf;
    logic [NOM_W-1:0]  r_tp, r_th;
    logic [TIME_W-1:0] r_prev;
    logic              r_have;

    // fold work registers
    logic signed [DPH_W-1:0] r_dph;
    logic signed [TIME_W:0]  r_ui;
    logic [UIC_W-1:0]        r_uic;
    logic signed [63:0]      r_fph;
    logic                    r_freq_en;
    logic [DVS_W-1:0]        r_n;
    logic signed [DPH_W-1:0] r_fdp;
    logic [MAG_W-1:0]        r_fmag, r_pmag;
    logic                    r_fneg, r_pneg;
    logic [PROD_W-1:0]       r_prod;
    t_mop                    r_mop_d;
    logic [ACC_W-1:0]        r_acc;
    logic signed [TERM_W-1:0] r_term;

    // pending tick and output beat
    logic [TIME_W-1:0] r_pend_time;
    t_status           r_pend_stat;
    logic              r_pend_valid;
    t_out              r_out;
    logic              r_out_valid;

    // divider
    logic              w_div_busy;
    logic [DIV_W-1:0]  w_q;
    logic [DIV_W-1:0]  w_dvd;
    logic [DVS_W-1:0]  w_dvs;

    logic [NOM_W-2:0]        w_half;
    logic [NOM_W+FRAC_W-2:0] w_half_q;
    logic signed [UIC_W:0]   w_dcl;
    logic signed [63:0]      w_fph1, w_fph2;
    logic [UIC_W-1:0]        w_uic;
    logic [TIME_W+3:0]       w_ui10;
    logic [TIME_W-1:0]       w_uiu;
    logic [TIME_W-1:0]       w_sum1;
    logic [MAG_W:0]          w_fm, w_pm;
    logic [31:0]             w_opa;
    logic [GAIN_W-1:0]       w_g;
    logic [TERM_W-1:0]       w_neg_term;
    logic [TERM_W-1:0]       w_pf_add;
    logic [NOM_W+1:0]        w_bb;
    logic [POS_W:0]          w_t;
    logic [TIME_W-1:0]       w_tick;
    logic                    w_out_fill;

    assign w_half   = r_nom[NOM_W-1:1];
    assign w_half_q = {w_half, {FRAC_W{1'b0}}};
    assign w_uiu    = r_ui[TIME_W-1:0];

    always_comb begin
        if (r_dph > $signed(DPH_W'(UI_LIM))) begin
            w_dcl = $signed({1'b0, UI_LIM});
        end else if (r_dph < -$signed(DPH_W'(UI_LIM))) begin
            w_dcl = -$signed({1'b0, UI_LIM});
        end else begin
            w_dcl = r_dph[UIC_W:0];
        end
        w_fph1 = $signed({w_dcl, {FRAC_W{1'b0}}});
        if (r_dph > $signed(DPH_W'(w_half))) begin
            w_fph1 = w_fph1 - $signed(64'(r_pf));
        end
        w_fph2 = r_fph;
        if (r_fph < -$signed(64'(w_half_q))) begin
            w_fph2 = r_fph + $signed(64'(r_pf));
        end
        if (w_fph2 > $signed(64'(Q_LIM))) begin
            w_fph2 = $signed(64'(Q_LIM));
        end else if (w_fph2 < -$signed(64'(Q_LIM))) begin
            w_fph2 = -$signed(64'(Q_LIM));
        end
    end

    assign w_uic  = (w_uiu > TIME_W'(UI_LIM)) ? UI_LIM : w_uiu[UIC_W-1:0];
    assign w_ui10 = {w_uiu, 3'b000} + {2'b00, w_uiu, 1'b0};
    assign w_sum1 = {1'b0, r_uic, 1'b0} + TIME_W'(r_nom);

    assign w_dvd = i_cmd.div_sel ? {2'b00, r_uic, {FRAC_W{1'b0}}} : DIV_W'(w_sum1);
    assign w_dvs = i_cmd.div_sel ? r_n : {7'b0, r_nom, 1'b0};

    assign w_fm = f_mag(r_fdp);
    assign w_pm = f_mag(DPH_W'(r_fph));

    always_comb begin
        case (i_cmd.mop)
            MOP_FHI: begin w_opa = 32'(r_fmag[MAG_W-1:32]); w_g = G_FREQ;  end
            MOP_FLO: begin w_opa = r_fmag[31:0];            w_g = G_FREQ;  end
            MOP_PHI: begin w_opa = 32'(r_pmag[MAG_W-1:32]); w_g = G_PHASE; end
            MOP_PLO: begin w_opa = r_pmag[31:0];            w_g = G_PHASE; end
            MOP_BHI: begin w_opa = 32'(r_pf[PER_W-1:32]);   w_g = G_BANG;  end
            MOP_BLO: begin w_opa = r_pf[31:0];              w_g = G_BANG;  end
            default: begin w_opa = '0;                      w_g = '0;      end
        endcase
    end

    assign w_neg_term = TERM_W'(-r_term);
    assign w_pf_add   = TERM_W'(r_pf) + w_neg_term;
    assign w_bb       = r_acc[ACC_W-1:FRAC_W];
    assign w_t        = {1'b0, r_pos} + (POS_W+1)'(r_th);
    assign w_tick     = (w_t > (POS_W+1)'(TIME_MAX)) ? TIME_MAX : w_t[TIME_W-1:0];
    assign w_out_fill = (i_cmd.emit && r_pend_valid) || i_cmd.finalize;

    etccr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_div_busy),
        .o_quot     (w_q)
    );

    // config and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nom        <= NOM_RST;
            r_minp       <= MINP_RST;
            r_cap        <= TIME_MAX;
            r_have       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NOMINAL:     r_nom  <= i_cfg_data[NOM_W-1:0];
                    CFG_MIN_PERIOD:  r_minp <= i_cfg_data[NOM_W-1:0];
                    CFG_CAPTURE_END: r_cap  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.seed) begin
                r_have <= 1'b0;
            end else if (i_cmd.set_prev || i_cmd.nudge) begin
                r_have <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finalize) begin
                r_pend_valid <= 1'b0;
            end
            if (w_out_fill) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_edge <= i_in.edge_time;
            r_fin  <= i_in.final_edge;
        end
        if (i_cmd.seed) begin
            r_pos  <= POS_W'(r_edge);
            r_pf   <= {r_nom, {FRAC_W{1'b0}}};
            r_tp   <= r_nom;
            r_th   <= NOM_W'(w_half);
            r_prev <= '0;
        end
        if (i_cmd.set_half) begin
            r_th <= {1'b0, r_tp[NOM_W-1:1]};
        end
        if (i_cmd.set_prev) begin
            r_prev <= r_edge;
        end
        if (i_cmd.f1) begin
            r_dph <= $signed({2'b00, r_pos}) - $signed(DPH_W'(r_edge))
                   - $signed(DPH_W'(r_tp));
            r_ui  <= $signed({1'b0, r_edge}) - $signed({1'b0, r_prev});
        end
        if (i_cmd.f2) begin
            r_fph     <= w_fph1;
            r_uic     <= w_uic;
            r_freq_en <= (r_nom != '0) && !r_ui[TIME_W] && (w_ui10 > (TIME_W+4)'(r_nom));
        end
        if (i_cmd.f3) begin
            r_fph <= w_fph2;
        end
        if (i_cmd.take_n) begin
            r_n <= w_q[DVS_W-1:0];
        end
        if (i_cmd.freq_off) begin
            r_freq_en <= 1'b0;
        end
        if (i_cmd.fdp) begin
            r_fdp <= r_freq_en ? ($signed(DPH_W'(r_pf)) - $signed(DPH_W'(w_q))) : '0;
        end
        if (i_cmd.mag) begin
            r_fneg <= w_fm[MAG_W];
            r_fmag <= w_fm[MAG_W-1:0];
            r_pneg <= w_pm[MAG_W];
            r_pmag <= w_pm[MAG_W-1:0];
        end
        r_prod  <= w_opa * w_g;
        r_mop_d <= i_cmd.mop;
        case (r_mop_d)
            MOP_FHI, MOP_PHI, MOP_BHI: r_acc <= ACC_W'(r_prod);
            MOP_FLO, MOP_PLO, MOP_BLO: r_acc <= r_acc + ACC_W'(r_prod[PROD_W-1:32]);
            default: ;
        endcase
        if (i_cmd.term_freq) begin
            r_term <= r_fneg ? -$signed(TERM_W'(r_acc)) : $signed(TERM_W'(r_acc));
        end
        if (i_cmd.term_phase) begin
            r_term <= r_pneg ? (r_term - $signed(TERM_W'(r_acc)))
                             : (r_term + $signed(TERM_W'(r_acc)));
        end
        if (i_cmd.pupd) begin
            if (r_term > 0) begin
                r_pf <= (r_term > $signed(TERM_W'(r_pf))) ? '0
                      : (r_pf - r_term[PER_W-1:0]);
            end else if (r_term < 0) begin
                r_pf <= (w_pf_add > TERM_W'(PER_MAX)) ? PER_MAX : w_pf_add[PER_W-1:0];
            end
        end
        if (i_cmd.tp_upd) begin
            r_tp <= r_pf[PER_W-1:FRAC_W];
        end
        if (i_cmd.nudge) begin
            // bang-bang: pull in if the tick ran late, push out otherwise
            if (r_dph > 0) begin
                r_pos <= (r_pos < POS_W'(w_bb)) ? '0 : (r_pos - POS_W'(w_bb));
            end else begin
                r_pos <= r_pos + POS_W'(w_bb);
            end
            r_prev <= r_edge;
        end
        if (i_cmd.adv) begin
            r_pos <= r_pos + POS_W'(r_tp);
        end
        if (i_cmd.emit) begin
            r_pend_time <= w_tick;
            r_pend_stat <= i_cmd.emit_status;
        end else if (i_cmd.pend_wr) begin
            r_pend_stat <= i_cmd.pend_status;
        end
        if (w_out_fill) begin
            r_out <= t_out'{tick_time: r_pend_time, tick_status: r_pend_stat,
                            run_last: i_cmd.finalize};
        end
    end

    assign o_sts = t_sts'{
        fin:        r_fin,
        have_prev:  r_have,
        fold:       (POS_W'({1'b0, r_edge} + (TIME_W+1)'(r_th)) < r_pos),
        cap_hit:    (r_pos >= POS_W'(r_cap)),
        freq_en:    r_freq_en,
        n_zero:     (r_n == '0),
        div_busy:   w_div_busy,
        nyq:        (r_tp < r_minp),
        pend_valid: r_pend_valid,
        out_free:   (!r_out_valid || i_out_ready)
    };

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/etccr_ctrl.sv
// Controller: loop phase, per-edge tick count and the sequencer that drives the datapath.
// Depends on etccr_pkg.
module etccr_ctrl import etccr_pkg::*; #(
    parameter int MAX_TICKS_PER_EDGE = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CNT_W = $clog2(MAX_TICKS_PER_EDGE + 1);

    typedef enum logic [29:0] {
        S_WAIT  = 30'd1 << 0,
        S_START = 30'd1 << 1,
        S_LOOP  = 30'd1 << 2,
        S_CHK   = 30'd1 << 3,
        S_F1    = 30'd1 << 4,
        S_F2    = 30'd1 << 5,
        S_F3    = 30'd1 << 6,
        S_D1    = 30'd1 << 7,
        S_D1W   = 30'd1 << 8,
        S_NCHK  = 30'd1 << 9,
        S_D2    = 30'd1 << 10,
        S_D2W   = 30'd1 << 11,
        S_FDP   = 30'd1 << 12,
        S_MAG   = 30'd1 << 13,
        S_M0    = 30'd1 << 14,
        S_M1    = 30'd1 << 15,
        S_M2    = 30'd1 << 16,
        S_M3    = 30'd1 << 17,
        S_M4    = 30'd1 << 18,
        S_M5    = 30'd1 << 19,
        S_M6    = 30'd1 << 20,
        S_PUPD  = 30'd1 << 21,
        S_TP    = 30'd1 << 22,
        S_B1    = 30'd1 << 23,
        S_B2    = 30'd1 << 24,
        S_B3    = 30'd1 << 25,
        S_EMIT  = 30'd1 << 26,
        S_ADV   = 30'd1 << 27,
        S_ADV2  = 30'd1 << 28,
        S_END   = 30'd1 << 29
    } t_state;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TOP  = 4'b0010,
        PH_ITER = 4'b0100,
        PH_STOP = 4'b1000
    } t_phase;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_nyq, n_nyq;
    t_cmd             w_cmd;

    assign o_in_ready = (r_state == S_WAIT);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_count = r_count;
        n_nyq   = r_nyq;
        w_cmd   = '0;
        w_cmd.mop         = MOP_NONE;
        w_cmd.emit_status = ST_NORMAL;
        w_cmd.pend_status = ST_NORMAL;
        case (r_state)
            S_WAIT: begin
                if (i_in_valid) begin
                    w_cmd.take = 1'b1;
                    n_count    = '0;
                    n_nyq      = 1'b0;
                    n_state    = S_START;
                end
            end
            S_START: begin
                case (r_phase)
                    PH_IDLE: begin
                        w_cmd.seed = 1'b1;
                        n_phase    = PH_TOP;
                        n_state    = S_END;
                    end
                    PH_STOP: n_state = S_END;
                    default: n_state = S_LOOP;
                endcase
            end
            S_LOOP: begin
                if (r_phase == PH_TOP) begin
                    if (i_sts.fin || i_sts.cap_hit) begin
                        n_phase = PH_STOP;
                        n_state = S_END;
                    end else begin
                        w_cmd.set_half = 1'b1;
                        n_phase        = PH_ITER;
                        n_state        = S_CHK;
                    end
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_sts.fin && i_sts.fold) begin
                    if (i_sts.have_prev) begin
                        n_state = S_F1;
                    end else begin
                        w_cmd.set_prev = 1'b1;
                        n_state        = S_END;
                    end
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_F1: begin w_cmd.f1 = 1'b1; n_state = S_F2; end
            S_F2: begin w_cmd.f2 = 1'b1; n_state = S_F3; end
            S_F3: begin
                w_cmd.f3 = 1'b1;
                n_state  = i_sts.freq_en ? S_D1 : S_FDP;
            end
            S_D1: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_D1W;
            end
            S_D1W: begin
                if (!i_sts.div_busy) begin
                    w_cmd.take_n = 1'b1;
                    n_state      = S_NCHK;
                end
            end
            S_NCHK: begin
                if (i_sts.n_zero) begin
                    w_cmd.freq_off = 1'b1;
                    n_state        = S_FDP;
                end else begin
                    n_state = S_D2;
                end
            end
            S_D2: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = 1'b1;
                n_state         = S_D2W;
            end
            S_D2W: begin
                if (!i_sts.div_busy) begin
                    n_state = S_FDP;
                end
            end
            S_FDP: begin w_cmd.fdp = 1'b1; n_state = S_MAG; end
            S_MAG: begin w_cmd.mag = 1'b1; n_state = S_M0; end
            S_M0:  begin w_cmd.mop = MOP_FHI; n_state = S_M1; end
            S_M1:  begin w_cmd.mop = MOP_FLO; n_state = S_M2; end
            S_M2:  n_state = S_M3;
            S_M3: begin
                w_cmd.term_freq = 1'b1;
                w_cmd.mop       = MOP_PHI;
                n_state         = S_M4;
            end
            S_M4:  begin w_cmd.mop = MOP_PLO; n_state = S_M5; end
            S_M5:  n_state = S_M6;
            S_M6:  begin w_cmd.term_phase = 1'b1; n_state = S_PUPD; end
            S_PUPD: begin w_cmd.pupd = 1'b1; n_state = S_TP; end
            S_TP: begin
                w_cmd.tp_upd = 1'b1;
                w_cmd.mop    = MOP_BHI;
                n_state      = S_B1;
            end
            S_B1:  begin w_cmd.mop = MOP_BLO; n_state = S_B2; end
            S_B2:  n_state = S_B3;
            S_B3: begin
                w_cmd.nudge = 1'b1;
                if (i_sts.nyq) begin
                    n_nyq   = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_END;
                end
            end
            S_EMIT: begin
                if (r_count >= CNT_W'(MAX_TICKS_PER_EDGE)) begin
                    w_cmd.pend_wr     = 1'b1;
                    w_cmd.pend_status = ST_OVERRUN;
                    n_phase           = PH_STOP;
                    n_state           = S_END;
                end else if (!i_sts.pend_valid || i_sts.out_free) begin
                    w_cmd.emit        = 1'b1;
                    w_cmd.emit_status = r_nyq ? ST_NYQUIST : ST_NORMAL;
                    n_count           = r_count + 1'b1;
                    if (r_nyq) begin
                        n_phase = PH_STOP;
                        n_state = S_END;
                    end else begin
                        n_state = S_ADV;
                    end
                end
            end
            S_ADV: begin w_cmd.adv = 1'b1; n_state = S_ADV2; end
            S_ADV2: begin
                if (i_sts.fin || i_sts.cap_hit) begin
                    w_cmd.pend_wr     = 1'b1;
                    w_cmd.pend_status = ST_END;
                    n_phase           = PH_STOP;
                    n_state           = S_END;
                end else begin
                    n_phase = PH_TOP;
                    n_state = S_LOOP;
                end
            end
            S_END: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    w_cmd.finalize = i_sts.pend_valid;
                    if (i_sts.fin) begin
                        n_phase = PH_IDLE;
                    end
                    n_state = S_WAIT;
                end
            end
            default: n_state = S_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_nyq   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_nyq   <= n_nyq;
        end
    end

    assign o_cmd = w_cmd;

    // a pending tick is never overwritten before it moves to the output
    a_pend_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && i_sts.pend_valid) |-> i_sts.out_free)
        else $error("pending tick overwritten");

    // every tick of an item has left the pending slot before the next item
    a_take_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.take |-> !i_sts.pend_valid)
        else $error("item taken with tick pending");

    a_count_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TICKS_PER_EDGE))
        else $error("tick count beyond limit");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider restarted while busy");

    // the item's final flag keeps its value across a finalize
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finalize |=> i_sts.fin == $past(i_sts.fin))
        else $error("final flag changed at end of item");

endmodule

>>> rtl/edge_timestamp_clock_recovery_pll.sv
// Top level of the edge-timestamp clock recovery PLL.
// Depends on etccr_pkg, etccr_ctrl, etccr_dp (and etccr_div below it).
//
// Digital CDR: each input beat is one data-edge timestamp (fs). The first
// edge of a stream seeds the NCO; later edges make the NCO emit ticks at
// position + half period until the edge falls before the pending tick, and
// that edge is then folded into the loop (phase gain 0.002, frequency gain
// 0.006 with glitch rejection, bang-bang nudge of 0.25% of the period).
// Each output beat is one tick; run_last marks the final beat of an input
// beat. Timing: a seeding edge or an edge seen while stopped passes only
// start and end; each tick adds a loop check, an emit and an advance; a
// folded edge adds the one-bit-per-cycle divider running two 64-step
// divisions back to back (UI count, then per-UI length) when frequency
// tracking is on, plus the shared 32x25 gain multiplier used six times.
// The block takes the next input beat while the last tick still waits in
// the output register. Configuration writes are taken in any cycle (ready
// is held high) and must only happen while the block is idle.
module edge_timestamp_clock_recovery_pll import etccr_pkg::*; #(
    parameter int MAX_TICKS_PER_EDGE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [TIME_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    etccr_ctrl #(
        .MAX_TICKS_PER_EDGE (MAX_TICKS_PER_EDGE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    etccr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule
